@@ sv/lbfg_pkg.sv @@
// shared types and constants for the load based frequency governor
package lbfg_pkg;

    localparam int unsigned FreqW = 22;
    localparam logic [31:0] MinWindowUs = 32'd1000;
    localparam logic [6:0] FullLoad = 7'd100;

    // frequency table geometry
    localparam int unsigned TableDepth = 8;
    localparam int unsigned TableIdxW = 3;
    localparam int unsigned TableCntW = 4;

    // ceil(2^37 / 100), exact floor division by 100 for any 32-bit value
    localparam logic [30:0] Recip100 = 31'd1374389535;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_COMMIT  = 2'd1,
        OP_RESTART = 2'd2,
        OP_TABLE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CHANGED   = 3'd0,
        ST_UNCHANGED = 3'd1,
        ST_SHORT     = 3'd2,
        ST_HOLDOFF   = 3'd3,
        ST_NOMATCH   = 3'd4,
        ST_INACTIVE  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_UP   = 2'd1,
        ACT_DOWN = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        CFG_ENABLED  = 3'd0,
        CFG_HISPEED  = 3'd1,
        CFG_GOLOAD   = 3'd2,
        CFG_MINTIME  = 3'd3,
        CFG_PMIN     = 3'd4,
        CFG_PMAX     = 3'd5,
        CFG_ENTRIES  = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_SHORT,
        S_DIV_LONG,
        S_MUL,
        S_WANT_DIV,
        S_SCAN,
        S_DECIDE,
        S_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic simple;
        logic div_start;
        logic div_long;
        logic load_sel;
        logic mul_go;
        logic scan_start;
        logic decide;
        logic out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_sample;
        logic short_win;
        logic div_done;
        logic scan_done;
    } sts_t;

endpackage

@@ sv/lbfg_div.sv @@
// restoring divider, one quotient bit per cycle
module lbfg_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [38:0] dividend,
    input  logic [31:0] divisor,
    output logic [38:0] quotient,
    output logic        done
);

    logic [38:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    // one shift and subtract step
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[31:0], q_reg[38]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 6'd39;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[37:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[37:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

@@ sv/lbfg_datapath.sv @@
// datapath: state, loads, target scaling and table scan
module lbfg_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lbfg_pkg::cmd_t        cmd,
    output lbfg_pkg::sts_t        sts,
    input  logic                  cfg_valid,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic [1:0]            op,
    input  logic [31:0]           now_time,
    input  logic [31:0]           idle_count,
    input  logic [21:0]           current_freq,
    input  logic                  cpu_idling,
    input  logic [2:0]            entry_index,
    input  logic [21:0]           entry_freq,
    output logic [2:0]            status,
    output logic [1:0]            action,
    output logic [21:0]           new_target,
    output logic [6:0]            load_percent,
    output logic                  arm_timer,
    output logic                  idle_cancel
);

    // configuration
    logic        enabled_reg;
    logic [21:0] hispeed_reg, pmin_reg, pmax_reg;
    logic [6:0]  goload_reg;
    logic [31:0] mintime_reg;
    logic [3:0]  entries_reg;

    // governor state
    logic [31:0] win_t_reg, win_i_reg, chg_t_reg, chg_i_reg;
    logic        win_valid_reg;
    logic [21:0] target_reg;
    logic [21:0] freq_mem [lbfg_pkg::TableDepth];

    // captured beat
    logic [1:0]  op_reg;
    logic [31:0] t_reg, i_reg;
    logic [21:0] cur_reg;
    logic        idl_reg;

    // work registers
    logic [6:0]  load_reg, l1_reg;
    logic [28:0] prod_reg;
    logic [21:0] want_reg;
    logic [lbfg_pkg::TableCntW-1:0] scan_reg;
    logic [lbfg_pkg::TableCntW-1:0] n_ent;
    logic        lo_ok_reg, hi_ok_reg;
    logic [21:0] lo_reg, hi_reg;
    logic [2:0]  status_reg;
    logic [1:0]  action_reg;
    logic [6:0]  lout_reg;
    logic        arm_reg, ic_reg;

    logic [31:0] dt_w, di_w, dt_c, di_c, div_t, div_i;
    logic [38:0] div_num, div_q;
    logic [31:0] div_den;
    logic        div_done, div_zero;
    logic        want_direct;
    logic [59:0] want_prod;

    assign dt_w = t_reg - win_t_reg;
    assign di_w = i_reg - win_i_reg;
    assign dt_c = t_reg - chg_t_reg;
    assign di_c = i_reg - chg_i_reg;
    assign div_t = cmd.div_long ? dt_c : dt_w;
    assign div_i = cmd.div_long ? di_c : di_w;
    assign div_zero = (div_t == 32'd0) || (div_i > div_t);
    assign div_num = {7'd0, div_t - div_i} * 39'd100;
    assign div_den = div_t;

    lbfg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_q),
        .done     (div_done)
    );

    // zero-load flag kept for the running division
    logic zero_reg;

    assign n_ent = (entries_reg > 4'(lbfg_pkg::TableDepth)) ? 4'(lbfg_pkg::TableDepth)
                   : entries_reg;

    assign sts.is_sample   = (op_reg == lbfg_pkg::OP_SAMPLE) && enabled_reg
                             && win_valid_reg;
    assign sts.short_win   = dt_w < lbfg_pkg::MinWindowUs;
    assign sts.div_done    = div_done;
    assign sts.scan_done   = (scan_reg >= n_ent);

    // high-speed jump from minimum, else scaled target
    assign want_direct = (load_reg >= goload_reg) && (cur_reg == pmin_reg);
    // product over 100 by reciprocal multiplication
    assign want_prod   = {31'd0, prod_reg} * {29'd0, lbfg_pkg::Recip100};

    logic [21:0] f_scan, pick;
    logic        pick_ok, rearm, arm_c, ic_c, do_change;
    logic [2:0]  st_c;
    logic [1:0]  act_c;
    logic [21:0] tgt_c;
    assign f_scan = freq_mem[scan_reg[lbfg_pkg::TableIdxW-1:0]];

    // final decision
    always_comb
    begin
        pick_ok   = lo_ok_reg | hi_ok_reg;
        pick      = lo_ok_reg ? lo_reg : hi_reg;
        st_c      = lbfg_pkg::ST_CHANGED;
        act_c     = lbfg_pkg::ACT_NONE;
        tgt_c     = target_reg;
        rearm     = 1'b1;
        do_change = 1'b0;
        if (cmd.simple)
            st_c = lbfg_pkg::ST_SHORT;
        else if (!pick_ok)
            st_c = lbfg_pkg::ST_NOMATCH;
        else if (pick == target_reg)
        begin
            st_c  = lbfg_pkg::ST_UNCHANGED;
            rearm = target_reg != pmax_reg;
        end
        else if (pick < target_reg && dt_c < mintime_reg)
            st_c = lbfg_pkg::ST_HOLDOFF;
        else
        begin
            do_change = 1'b1;
            act_c = (pick < target_reg) ? lbfg_pkg::ACT_DOWN : lbfg_pkg::ACT_UP;
            tgt_c = pick;
            rearm = pick != pmax_reg;
        end
        arm_c = 1'b0;
        ic_c  = 1'b0;
        if (rearm)
        begin
            if (tgt_c == pmin_reg)
            begin
                arm_c = !idl_reg;
                ic_c  = !idl_reg;
            end
            else
                arm_c = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            hispeed_reg   <= 22'h3FFFFF;
            goload_reg    <= 7'd90;
            mintime_reg   <= 32'd10000;
            pmin_reg      <= '0;
            pmax_reg      <= 22'h3FFFFF;
            entries_reg   <= 4'd8;
            win_t_reg     <= '0;
            win_i_reg     <= '0;
            win_valid_reg <= 1'b0;
            chg_t_reg     <= '0;
            chg_i_reg     <= '0;
            target_reg    <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    lbfg_pkg::CFG_ENABLED:
                    begin
                        enabled_reg <= cfg_data[0];
                        if (!cfg_data[0])
                            win_valid_reg <= 1'b0;
                    end
                    lbfg_pkg::CFG_HISPEED: hispeed_reg <= cfg_data[21:0];
                    lbfg_pkg::CFG_GOLOAD:  goload_reg  <= cfg_data[6:0];
                    lbfg_pkg::CFG_MINTIME: mintime_reg <= cfg_data;
                    lbfg_pkg::CFG_PMIN:    pmin_reg    <= cfg_data[21:0];
                    lbfg_pkg::CFG_PMAX:    pmax_reg    <= cfg_data[21:0];
                    lbfg_pkg::CFG_ENTRIES: entries_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            // non-sample ops update state at capture
            if (cmd.capture && enabled_reg)
            begin
                if (op == lbfg_pkg::OP_COMMIT)
                begin
                    chg_t_reg <= now_time;
                    chg_i_reg <= idle_count;
                end
                else if (op == lbfg_pkg::OP_RESTART)
                begin
                    win_t_reg     <= now_time;
                    win_i_reg     <= idle_count;
                    win_valid_reg <= 1'b1;
                end
            end
            if (cmd.decide)
            begin
                if (do_change && !cmd.simple)
                    target_reg <= pick;
                if (arm_c)
                begin
                    win_t_reg     <= t_reg;
                    win_i_reg     <= i_reg;
                    win_valid_reg <= 1'b1;
                end
            end
        end
    end

    // table write and work registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            t_reg   <= now_time;
            i_reg   <= idle_count;
            cur_reg <= current_freq;
            idl_reg <= cpu_idling;
            if (op == lbfg_pkg::OP_TABLE)
                freq_mem[entry_index] <= entry_freq;
        end
        if (cmd.div_start)
            zero_reg <= div_zero;
        // short-term load lands as the long-term division starts
        if (div_done && cmd.div_start)
            l1_reg <= zero_reg ? 7'd0 : div_q[6:0];
        if (cmd.load_sel)
            load_reg <= (zero_reg ? 7'd0 : div_q[6:0]) > l1_reg
                        ? (zero_reg ? 7'd0 : div_q[6:0]) : l1_reg;
        if (cmd.mul_go)
            prod_reg <= (load_reg >= goload_reg) ? {7'd0, pmax_reg} * {22'd0, load_reg}
                        : {7'd0, cur_reg} * {22'd0, load_reg};
        if (cmd.scan_start)
        begin
            want_reg  <= want_direct ? hispeed_reg : want_prod[58:37];
            scan_reg  <= '0;
            lo_ok_reg <= 1'b0;
            hi_ok_reg <= 1'b0;
        end
        else if (!sts.scan_done)
        begin
            scan_reg <= scan_reg + 4'd1;
            if (f_scan >= pmin_reg && f_scan <= pmax_reg)
            begin
                if (f_scan <= want_reg)
                begin
                    if (!lo_ok_reg || f_scan >= lo_reg)
                    begin
                        lo_reg    <= f_scan;
                        lo_ok_reg <= 1'b1;
                    end
                end
                else if (!hi_ok_reg || f_scan <= hi_reg)
                begin
                    hi_reg    <= f_scan;
                    hi_ok_reg <= 1'b1;
                end
            end
        end
        if (cmd.decide)
        begin
            status_reg <= st_c;
            action_reg <= act_c;
            lout_reg   <= cmd.simple ? 7'd0 : load_reg;
            arm_reg    <= arm_c;
            ic_reg     <= ic_c;
        end
        else if (cmd.out_load)
        begin
            // non-sample or inactive result
            status_reg <= lbfg_pkg::ST_INACTIVE;
            action_reg <= lbfg_pkg::ACT_NONE;
            lout_reg   <= '0;
            arm_reg    <= (op_reg == lbfg_pkg::OP_RESTART) && enabled_reg;
            ic_reg     <= 1'b0;
        end
    end

    assign status       = status_reg;
    assign action       = action_reg;
    assign new_target   = target_reg;
    assign load_percent = lout_reg;
    assign arm_timer    = arm_reg;
    assign idle_cancel  = ic_reg;

endmodule

@@ sv/lbfg_ctrl.sv @@
// controller state machine sequencing one event
module lbfg_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output lbfg_pkg::cmd_t cmd,
    input  lbfg_pkg::sts_t sts
);

    lbfg_pkg::state_t state_reg, state_next;
    logic simple_reg, simple_next;
    logic ovalid_reg, ovalid_next;
    logic out_take;

    assign out_take = ovalid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lbfg_pkg::S_IDLE;
            simple_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            simple_reg <= simple_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        simple_next = simple_reg;
        ovalid_next = ovalid_reg && !out_take;
        cmd         = '0;
        cmd.simple  = simple_reg;
        in_stall    = 1'b1;
        case (state_reg)
            lbfg_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = lbfg_pkg::S_DIV_SHORT;
                end
            end
            lbfg_pkg::S_DIV_SHORT:
            begin
                if (!sts.is_sample)
                    state_next = lbfg_pkg::S_OUT;
                else if (sts.short_win)
                begin
                    simple_next = 1'b1;
                    state_next  = lbfg_pkg::S_DECIDE;
                end
                else
                begin
                    simple_next   = 1'b0;
                    cmd.div_start = 1'b1;
                    state_next    = lbfg_pkg::S_DIV_LONG;
                end
            end
            lbfg_pkg::S_DIV_LONG:
            begin
                if (sts.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_long  = 1'b1;
                    state_next    = lbfg_pkg::S_MUL;
                end
            end
            lbfg_pkg::S_MUL:
            begin
                cmd.div_long = 1'b1;
                if (sts.div_done)
                begin
                    cmd.load_sel = 1'b1;
                    state_next   = lbfg_pkg::S_WANT_DIV;
                end
            end
            lbfg_pkg::S_WANT_DIV:
            begin
                cmd.mul_go = 1'b1;
                state_next = lbfg_pkg::S_SCAN;
            end
            lbfg_pkg::S_SCAN:
            begin
                cmd.scan_start = 1'b1;
                state_next     = lbfg_pkg::S_DECIDE;
            end
            lbfg_pkg::S_DECIDE:
            begin
                if (simple_reg || (sts.scan_done && !cmd.scan_start))
                begin
                    if (!ovalid_reg || out_take)
                    begin
                        cmd.decide  = 1'b1;
                        ovalid_next = 1'b1;
                        simple_next = 1'b0;
                        state_next  = lbfg_pkg::S_IDLE;
                    end
                end
            end
            lbfg_pkg::S_OUT:
            begin
                // wait until the previous result beat is gone
                if (!ovalid_reg || out_take)
                begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = lbfg_pkg::S_IDLE;
                end
            end
            default: state_next = lbfg_pkg::S_IDLE;
        endcase
    end

    assign out_valid = ovalid_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lbfg_pkg::S_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_decide_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |=> out_valid)
        else $error("decision without result");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped");
`endif

endmodule

@@ sv/load_based_frequency_governor.sv @@
// top level of the load based frequency governor
// One event at a time. Commit, restart, table-write, inactive and short-window
// events go from capture through a status check straight to the result. A full
// sample runs two passes through a 39-step bit-serial divider (short- and
// long-term load), a multiply, a reciprocal scaling step and a scan of the
// frequency table entries in use. The next event is taken while the previous
// result waits in the output register, but its own result is loaded only once
// that beat has been taken, so result-side stalls add directly to the event time.
module load_based_frequency_governor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [31:0] now_time,
    input  logic [31:0] idle_count,
    input  logic [21:0] current_freq,
    input  logic        cpu_idling,
    input  logic [2:0]  entry_index,
    input  logic [21:0] entry_freq,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [1:0]  action,
    output logic [21:0] new_target,
    output logic [6:0]  load_percent,
    output logic        arm_timer,
    output logic        idle_cancel
);

    lbfg_pkg::cmd_t cmd;
    lbfg_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    lbfg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    lbfg_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op           (op),
        .now_time     (now_time),
        .idle_count   (idle_count),
        .current_freq (current_freq),
        .cpu_idling   (cpu_idling),
        .entry_index  (entry_index),
        .entry_freq   (entry_freq),
        .status       (status),
        .action       (action),
        .new_target   (new_target),
        .load_percent (load_percent),
        .arm_timer    (arm_timer),
        .idle_cancel  (idle_cancel)
    );

endmodule

@@ tb/load_based_frequency_governor_tb.sv @@
// self-checking testbench for the load based frequency governor
module load_based_frequency_governor_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = lbfg_pkg::TableDepth;
    localparam logic [21:0] FMAX = 22'h3FFFFF;

    typedef struct packed {
        lbfg_pkg::op_t op;
        logic [31:0] t;
        logic [31:0] idle;
        logic [21:0] cur;
        logic        idling;
        logic [2:0]  idx;
        logic [21:0] efreq;
    } gov_event_t;

    typedef struct packed {
        lbfg_pkg::status_t st;
        lbfg_pkg::action_t act;
        logic [21:0] tgt;
        logic [6:0]  load;
        logic        arm;
        logic        icancel;
    } gov_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = '0;
    logic [31:0] now_time = '0;
    logic [31:0] idle_count = '0;
    logic [21:0] current_freq = '0;
    logic        cpu_idling = 1'b0;
    logic [2:0]  entry_index = '0;
    logic [21:0] entry_freq = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [1:0]  action;
    logic [21:0] new_target;
    logic [6:0]  load_percent;
    logic        arm_timer;
    logic        idle_cancel;

    load_based_frequency_governor u_dut (.*);

    always #2 clk = ~clk;

    // predictor copy of configuration and state
    logic        gov_en = 1'b0;
    logic [21:0] gov_hispeed = FMAX;
    logic [6:0]  gov_goload = 7'd90;
    logic [31:0] gov_mintime = 32'd10000;
    logic [21:0] gov_pmin = '0;
    logic [21:0] gov_pmax = FMAX;
    logic [3:0]  gov_entries = 4'd8;
    logic [31:0] win_time = '0, win_idle = '0, chg_time = '0, chg_idle = '0;
    logic        win_open = 1'b0;
    logic [21:0] gov_target = '0;
    logic [21:0] freq_tab [DEPTH];

    gov_event_t  pend_q [$];
    gov_result_t expected_q [$];
    gov_event_t  beat_on_bus;
    int          errors = 0;
    int          n_checked = 0;
    int          status_seen [6];

    // stimulus generator state
    logic [31:0] gen_time, gen_idle;

    function automatic logic [6:0] load_over(logic [31:0] dt, logic [31:0] di);
        logic [63:0] busy;
        if (dt == 0 || di > dt)
            return 7'd0;
        busy = 64'(dt - di) * 64'd100;
        return 7'(busy / 64'(dt));
    endfunction

    function automatic bit pick_entry(input logic [31:0] want, output logic [21:0] hit);
        int n;
        bit have_lo, have_hi;
        logic [21:0] lo, hi, f;
        n = (gov_entries > DEPTH) ? DEPTH : int'(gov_entries);
        have_lo = 0; have_hi = 0; lo = '0; hi = '0; hit = '0;
        for (int k = 0; k < n; k++)
        begin
            f = freq_tab[k];
            if (f < gov_pmin || f > gov_pmax)
                continue;
            if (32'(f) <= want)
            begin
                if (!have_lo || f >= lo) begin lo = f; have_lo = 1; end
            end
            else if (!have_hi || f <= hi)
            begin
                hi = f; have_hi = 1;
            end
        end
        if (have_lo) hit = lo;
        else if (have_hi) hit = hi;
        return have_lo || have_hi;
    endfunction

    // one event through the governor, state updated
    function automatic gov_result_t predict_governor(gov_event_t e);
        gov_result_t r;
        logic [31:0] dt, di, want;
        logic [6:0]  l2, ld;
        logic [21:0] pick;
        bit          rearm;
        r = '{st: lbfg_pkg::ST_INACTIVE, act: lbfg_pkg::ACT_NONE, tgt: '0, load: '0,
              arm: 1'b0, icancel: 1'b0};
        rearm = 0;
        case (e.op)
            lbfg_pkg::OP_COMMIT:
                if (gov_en) begin chg_time = e.t; chg_idle = e.idle; end
            lbfg_pkg::OP_RESTART:
                if (gov_en)
                begin
                    win_time = e.t; win_idle = e.idle; win_open = 1; r.arm = 1;
                end
            lbfg_pkg::OP_TABLE:
                freq_tab[e.idx] = e.efreq;
            default:
                if (gov_en && win_open)
                begin
                    dt = e.t - win_time;
                    di = e.idle - win_idle;
                    if (dt < lbfg_pkg::MinWindowUs)
                    begin
                        r.st = lbfg_pkg::ST_SHORT;
                        rearm = 1;
                    end
                    else
                    begin
                        l2 = load_over(e.t - chg_time, e.idle - chg_idle);
                        ld = load_over(dt, di);
                        if (l2 > ld) ld = l2;
                        r.load = ld;
                        if (ld >= gov_goload)
                            want = (e.cur == gov_pmin) ? 32'(gov_hispeed)
                                 : (32'(gov_pmax) * 32'(ld)) / 32'd100;
                        else
                            want = (32'(e.cur) * 32'(ld)) / 32'd100;
                        if (!pick_entry(want, pick))
                        begin
                            r.st = lbfg_pkg::ST_NOMATCH;
                            rearm = 1;
                        end
                        else if (pick == gov_target)
                        begin
                            r.st = lbfg_pkg::ST_UNCHANGED;
                            rearm = (gov_target != gov_pmax);
                        end
                        else if (pick < gov_target && (e.t - chg_time) < gov_mintime)
                        begin
                            r.st = lbfg_pkg::ST_HOLDOFF;
                            rearm = 1;
                        end
                        else
                        begin
                            r.act = (pick < gov_target) ? lbfg_pkg::ACT_DOWN
                                                        : lbfg_pkg::ACT_UP;
                            gov_target = pick;
                            r.st = lbfg_pkg::ST_CHANGED;
                            rearm = (gov_target != gov_pmax);
                        end
                    end
                    if (rearm)
                    begin
                        if (gov_target == gov_pmin)
                        begin
                            if (!e.idling) begin r.icancel = 1; r.arm = 1; end
                        end
                        else
                            r.arm = 1;
                        if (r.arm) begin win_time = e.t; win_idle = e.idle; win_open = 1; end
                    end
                end
        endcase
        r.tgt = gov_target;
        return r;
    endfunction

    // sender: bursts of beats with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (in_valid)
                expected_q.push_back(predict_governor(beat_on_bus));
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pend_q.size() > 0)
            begin
                beat_on_bus = pend_q.pop_front();
                op <= beat_on_bus.op;
                now_time <= beat_on_bus.t;
                idle_count <= beat_on_bus.idle;
                current_freq <= beat_on_bus.cur;
                cpu_idling <= beat_on_bus.idling;
                entry_index <= beat_on_bus.idx;
                entry_freq <= beat_on_bus.efreq;
                in_valid <= 1'b1;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: stall pattern that changes mode now and then
    int stall_mode = 0, mode_left = 0;
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(64, 600);
        end
        mode_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            2: out_stall <= (mode_left % 37) < 20;
            default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
        end
    endtask

    // monitor: compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected, status %0d",
                         $realtime, status);
            end
            else
            begin
                gov_result_t x;
                x = expected_q.pop_front();
                check_field("status", x.st, status);
                check_field("action", x.act, action);
                check_field("new_target", x.tgt, new_target);
                check_field("load_percent", x.load, load_percent);
                check_field("arm_timer", x.arm, arm_timer);
                check_field("idle_cancel", x.icancel, idle_cancel);
                n_checked++;
                if (x.st <= lbfg_pkg::ST_INACTIVE) status_seen[x.st]++;
            end
        end
    end

    task automatic write_reg(lbfg_pkg::cfg_idx_t idx, logic [31:0] d);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            lbfg_pkg::CFG_ENABLED: begin gov_en = d[0]; if (!d[0]) win_open = 0; end
            lbfg_pkg::CFG_HISPEED: gov_hispeed = d[21:0];
            lbfg_pkg::CFG_GOLOAD:  gov_goload = d[6:0];
            lbfg_pkg::CFG_MINTIME: gov_mintime = d;
            lbfg_pkg::CFG_PMIN:    gov_pmin = d[21:0];
            lbfg_pkg::CFG_PMAX:    gov_pmax = d[21:0];
            lbfg_pkg::CFG_ENTRIES: gov_entries = d[3:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic push_event(lbfg_pkg::op_t o, logic [31:0] dt, logic [31:0] di,
                              logic [21:0] cur, logic idl, logic [2:0] idx, logic [21:0] f);
        gen_time += dt;
        gen_idle += di;
        pend_q.push_back('{op: o, t: gen_time, idle: gen_idle, cur: cur, idling: idl,
                           idx: idx, efreq: f});
    endtask

    function automatic logic [21:0] pick_cur();
        case ($urandom_range(0, 5))
            0: return gov_pmin;
            1: return gov_target;
            2: return freq_tab[$urandom_range(0, DEPTH - 1)];
            3: return ($urandom_range(0, 1) == 1) ? FMAX : 22'd0;
            default: return 22'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] extreme_or(logic [31:0] lo, logic [31:0] hi,
                                               logic [31:0] rlo, logic [31:0] rhi);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            default: return $urandom_range(rhi, rlo);
        endcase
    endfunction

    // random event: mostly well-formed sample traffic, some noise
    task automatic push_random();
        logic [31:0] dt, di;
        int sel;
        sel = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0: dt = $urandom_range(0, 999);
            1: dt = $urandom();
            default: dt = $urandom_range(1000, 30000);
        endcase
        di = ($urandom_range(0, 9) == 0) ? dt + $urandom_range(1, 2000) : $urandom_range(0, dt);
        if (sel < 4)
        begin
            gen_time = $urandom();
            gen_idle = $urandom();
            push_event(lbfg_pkg::op_t'($urandom_range(0, 3)), 0, 0, 22'($urandom()),
                       1'($urandom()), 3'($urandom()), 22'($urandom()));
        end
        else if (sel < 64)
            push_event(lbfg_pkg::OP_SAMPLE, dt, di, pick_cur(), 1'($urandom()),
                       3'($urandom()), 22'($urandom()));
        else if (sel < 80)
            push_event(lbfg_pkg::OP_COMMIT, dt, di, pick_cur(), 1'($urandom()),
                       3'($urandom()), 22'($urandom()));
        else if (sel < 90)
            push_event(lbfg_pkg::OP_RESTART, dt, di, pick_cur(), 1'($urandom()),
                       3'($urandom()), 22'($urandom()));
        else
            push_event(lbfg_pkg::OP_TABLE, 0, 0, pick_cur(), 1'($urandom()), 3'($urandom()),
                       ($urandom_range(0, 2) == 0) ? 22'($urandom())
                                                   : 22'($urandom_range(200000, 2500000)));
    endtask

    initial
    begin
        gen_time = $urandom();
        gen_idle = $urandom();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // fill the whole table while the governor is off, plus ignored events
        for (int k = 0; k < DEPTH; k++)
            push_event(lbfg_pkg::OP_TABLE, 10, 0, 22'd0, 1'b0, 3'(k),
                       (k == 0) ? 22'd0 : (k == 7) ? FMAX : 22'(k * 300000));
        push_event(lbfg_pkg::OP_SAMPLE, 5000, 100, 22'd600000, 1'b0, 3'd0, 22'd0);
        push_event(lbfg_pkg::OP_RESTART, 100, 0, 22'd0, 1'b0, 3'd0, 22'd0);
        push_event(lbfg_pkg::OP_COMMIT, 100, 0, 22'd0, 1'b0, 3'd0, 22'd0);
        wait_drained();

        write_reg(lbfg_pkg::CFG_HISPEED, 32'd1500000);
        write_reg(lbfg_pkg::CFG_GOLOAD, 32'd90);
        write_reg(lbfg_pkg::CFG_MINTIME, 32'd10000);
        write_reg(lbfg_pkg::CFG_PMIN, 32'd0);
        write_reg(lbfg_pkg::CFG_PMAX, 32'(FMAX));
        write_reg(lbfg_pkg::CFG_ENTRIES, 32'd8);
        write_reg(lbfg_pkg::CFG_ENABLED, 32'd1);

        // directed: no window, short window, burst from minimum, scaling, hold-off
        push_event(lbfg_pkg::OP_SAMPLE, 100, 0, 22'd0, 1'b0, 3'd0, 22'd0);
        push_event(lbfg_pkg::OP_COMMIT, 100, 0, 22'd0, 1'b0, 3'd0, 22'd0);
        push_event(lbfg_pkg::OP_RESTART, 0, 0, 22'd0, 1'b0, 3'd0, 22'd0);
        push_event(lbfg_pkg::OP_SAMPLE, 500, 0, 22'd0, 1'b1, 3'd0, 22'd0);
        push_event(lbfg_pkg::OP_SAMPLE, 2000, 0, 22'd0, 1'b0, 3'd0, 22'd0);
        push_event(lbfg_pkg::OP_SAMPLE, 2000, 0, 22'd1500000, 1'b0, 3'd0, 22'd0);
        push_event(lbfg_pkg::OP_COMMIT, 0, 0, 22'd0, 1'b0, 3'd0, 22'd0);
        push_event(lbfg_pkg::OP_SAMPLE, 4000, 3000, 22'd1500000, 1'b0, 3'd0, 22'd0);
        push_event(lbfg_pkg::OP_COMMIT, 20000, 19000, 22'd0, 1'b0, 3'd0, 22'd0);
        // idle above elapsed with zero time since the change
        push_event(lbfg_pkg::OP_SAMPLE, 0, 5000, 22'd1500000, 1'b1, 3'd0, 22'd0);
        push_event(lbfg_pkg::OP_SAMPLE, 3000, 2900, 22'd1500000, 1'b0, 3'd0, 22'd0);
        push_event(lbfg_pkg::OP_SAMPLE, 3000, 0, FMAX, 1'b0, 3'd0, 22'd0);
        push_event(lbfg_pkg::OP_SAMPLE, 3000, 0, FMAX, 1'b0, 3'd0, 22'd0);
        push_event(lbfg_pkg::OP_SAMPLE, 3000, 1500, 22'd1200000, 1'b0, 3'd0, 22'd0);
        wait_drained();

        // random phases, each under a fresh register setting
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(lbfg_pkg::CFG_HISPEED, extreme_or(0, FMAX, 0, FMAX));
            write_reg(lbfg_pkg::CFG_GOLOAD,
                      (ph == 0) ? 0 : (ph == 1) ? 100 : extreme_or(0, 100, 30, 100));
            write_reg(lbfg_pkg::CFG_MINTIME,
                      (ph == 1) ? 32'hFFFFFFFF : extreme_or(0, 32'hFFFFFFFF, 0, 40000));
            write_reg(lbfg_pkg::CFG_PMIN,
                      (ph == 2) ? 32'(FMAX) : extreme_or(0, FMAX, 0, 900000));
            write_reg(lbfg_pkg::CFG_PMAX, extreme_or(0, FMAX, 1000000, FMAX));
            write_reg(lbfg_pkg::CFG_ENTRIES,
                      (ph == 3) ? 0 : (ph == 4) ? 15 : extreme_or(0, 15, 1, 8));
            write_reg(lbfg_pkg::CFG_ENABLED, ($urandom_range(0, 6) == 0) ? 0 : 1);
            push_event(lbfg_pkg::OP_RESTART, 10, 0, 22'd0, 1'b0, 3'd0, 22'd0);
            for (int k = 0; k < 250; k++)
                push_random();
            wait_drained();
            if (ph == 5)
                write_reg(lbfg_pkg::CFG_ENABLED, 0);
        end

        $display("checked %0d result beats: %0d changed, %0d unchanged, %0d short, %0d hold-off,",
                 n_checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        $display("  %0d without table match, %0d inactive or non-sample",
                 status_seen[4], status_seen[5]);
        if (errors == 0)
            $display("PASS load_based_frequency_governor");
        else
            $display("FAIL load_based_frequency_governor");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL load_based_frequency_governor");
        $finish;
    end

endmodule
